// ----- hdl/pfst_pkg.sv -----
// Shared constants, codes and types for the page frame state table.
package pfst_pkg;

  localparam int MaxFramesDefault = 4096;
  localparam int PageShiftDefault = 12;

  localparam int CountWidth  = 13;
  localparam int AddrInWidth = 32;
  localparam int FrameWidth  = 3;
  localparam int StatusWidth = 2;
  localparam int AddrOutWidth = 24;

  localparam logic [CountWidth-1:0] CountReset = 13'd4096;

  localparam logic [FrameWidth-1:0] FS_UNDEF = 3'd0;
  localparam logic [FrameWidth-1:0] FS_AVAIL = 3'd1;
  localparam logic [FrameWidth-1:0] FS_KPOOL = 3'd3;
  localparam logic [FrameWidth-1:0] FS_KUSED = 3'd4;

  typedef enum logic [StatusWidth-1:0] {
    RES_OK      = 2'd0,
    RES_BEYOND  = 2'd1,
    RES_DEFINED = 2'd2,
    RES_OOM     = 2'd3
  } status_t;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_PREP,
    S_RANGE,
    S_CHK_RD,
    S_CHK_CMP,
    S_WRITE,
    S_AL_RD,
    S_AL_CMP,
    S_DONE
  } ctrl_state_t;

endpackage

// ----- hdl/pfst_ram.sv -----
// Simple dual-port frame state memory with one write port and a registered read.
module pfst_ram #(
  parameter int DEPTH = pfst_pkg::MaxFramesDefault,
  parameter int AW    = $clog2(pfst_pkg::MaxFramesDefault),
  parameter int DW    = pfst_pkg::FrameWidth
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata
);

  logic [DW-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// ----- hdl/page_frame_state_table_unit.sv -----
// Page frame state table: per-frame state memory with mark and allocate sequencing.
// Mark: a range check, then a read-and-compare per frame checked (available only), then a write per frame.
// Allocate: a read-and-compare per frame, scanned from frame 0 to the first pool frame.
// One request is in work at a time; the next is taken while the previous result waits.
// Reset runs a clearing pass over all MAX_FRAMES memory entries; in_ready stays low meanwhile.
// Configuration writes are taken in every cycle, including during the clearing pass.
module page_frame_state_table_unit #(
  parameter int MAX_FRAMES = pfst_pkg::MaxFramesDefault,
  parameter int PAGE_SHIFT = pfst_pkg::PageShiftDefault
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [pfst_pkg::CountWidth-1:0]     cfg_data,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic                                command,
  input  logic [pfst_pkg::AddrInWidth-1:0]    start_addr,
  input  logic [pfst_pkg::AddrInWidth-1:0]    region_len,
  input  logic [pfst_pkg::FrameWidth-1:0]     new_state,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [pfst_pkg::StatusWidth-1:0]    status,
  output logic [pfst_pkg::AddrOutWidth-1:0]   frame_addr
);
  import pfst_pkg::*;

  localparam int FW  = $clog2(MAX_FRAMES);
  localparam int CW  = $clog2(MAX_FRAMES + 1);
  localparam int LW  = (CW > CountWidth) ? CW : CountWidth;
  localparam int SW  = AddrInWidth + 1;
  localparam int LFW = SW - PAGE_SHIFT;
  localparam int FIW = AddrInWidth - PAGE_SHIFT;
  localparam logic [SW-1:0] PageMask = SW'((64'd1 << PAGE_SHIFT) - 64'd1);

  ctrl_state_t state, state_next;

  logic [CountWidth-1:0]   frame_count;
  logic                    cmd_q;
  logic [AddrInWidth-1:0]  start_q;
  logic [AddrInWidth-1:0]  len_q;
  logic [FrameWidth-1:0]   nst_q;
  logic [LFW-1:0]          lastf_q;
  logic [FIW-1:0]          first_q;
  logic [LFW-1:0]          cnt_q;
  logic [CW-1:0]           idx, idx_next;
  logic [CW-1:0]           end_q, end_next;
  status_t                 res_q, res_next;
  logic [AddrOutWidth-1:0] addr_q, addr_next;

  logic [SW-1:0]           last_byte;
  logic [SW-1:0]           cnt_bytes;
  logic [LW-1:0]           fc_ext;
  logic [CW-1:0]           live;
  logic [CW-1:0]           idx_inc;
  logic [CW-1:0]           first_idx;
  logic [SW-1:0]           end_wide;
  logic [63:0]             addr_wide;

  logic                    mem_we;
  logic [FrameWidth-1:0]   mem_wdata;
  logic [FrameWidth-1:0]   rdata;

  pfst_ram #(
    .DEPTH (MAX_FRAMES),
    .AW    (FW),
    .DW    (FrameWidth)
  ) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (idx[FW-1:0]),
    .wdata (mem_wdata),
    .raddr (idx[FW-1:0]),
    .rdata (rdata)
  );

  assign cfg_ready = 1'b1;
  assign in_ready  = (state == S_IDLE);

  assign last_byte = SW'(start_q) + SW'(len_q) - SW'(1);
  assign cnt_bytes = SW'(len_q) + PageMask;
  assign fc_ext    = LW'(frame_count);
  assign live      = (fc_ext > LW'(MAX_FRAMES)) ? CW'(MAX_FRAMES) : CW'(fc_ext);
  assign idx_inc   = idx + CW'(1);
  assign first_idx = CW'(first_q);
  assign end_wide  = SW'(first_q) + SW'(cnt_q);
  assign addr_wide = 64'(idx) << PAGE_SHIFT;

  always_comb begin
    state_next = state;
    case (state)
      S_CLEAR: begin
        if (idx == CW'(MAX_FRAMES - 1)) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) state_next = S_PREP;
      end
      S_PREP: begin
        if (cmd_q) state_next = S_AL_RD;
        else if (len_q == '0) state_next = S_DONE;
        else state_next = S_RANGE;
      end
      S_RANGE: begin
        if (SW'(lastf_q) >= SW'(live)) state_next = S_DONE;
        else if (nst_q == FS_AVAIL) state_next = S_CHK_RD;
        else state_next = S_WRITE;
      end
      S_CHK_RD: state_next = S_CHK_CMP;
      S_CHK_CMP: begin
        if (rdata != FS_UNDEF) state_next = S_DONE;
        else if (idx_inc == end_q) state_next = S_WRITE;
        else state_next = S_CHK_RD;
      end
      S_WRITE: begin
        if (idx_inc == end_q) state_next = S_DONE;
      end
      S_AL_RD: begin
        if (idx >= live) state_next = S_DONE;
        else state_next = S_AL_CMP;
      end
      S_AL_CMP: begin
        if (rdata == FS_KPOOL) state_next = S_DONE;
        else state_next = S_AL_RD;
      end
      S_DONE: begin
        if (!out_valid || out_ready) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    idx_next  = idx;
    end_next  = end_q;
    res_next  = res_q;
    addr_next = addr_q;
    mem_we    = 1'b0;
    mem_wdata = nst_q;
    case (state)
      S_CLEAR: begin
        mem_we    = 1'b1;
        mem_wdata = FS_UNDEF;
        idx_next  = idx_inc;
      end
      S_IDLE: begin
        idx_next  = '0;
        res_next  = RES_OK;
        addr_next = '0;
      end
      S_RANGE: begin
        idx_next = first_idx;
        end_next = end_wide[CW-1:0];
        if (SW'(lastf_q) >= SW'(live)) res_next = RES_BEYOND;
      end
      S_CHK_CMP: begin
        if (rdata != FS_UNDEF) res_next = RES_DEFINED;
        else if (idx_inc == end_q) idx_next = first_idx;
        else idx_next = idx_inc;
      end
      S_WRITE: begin
        mem_we   = 1'b1;
        idx_next = idx_inc;
      end
      S_AL_RD: begin
        if (idx >= live) res_next = RES_OOM;
      end
      S_AL_CMP: begin
        if (rdata == FS_KPOOL) begin
          mem_we    = 1'b1;
          mem_wdata = FS_KUSED;
          addr_next = addr_wide[AddrOutWidth-1:0];
        end else begin
          idx_next = idx_inc;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_CLEAR;
      idx         <= '0;
      out_valid   <= 1'b0;
      frame_count <= CountReset;
    end else begin
      state <= state_next;
      idx   <= idx_next;
      if (cfg_valid && cfg_ready) frame_count <= cfg_data;
      if (state == S_DONE && (!out_valid || out_ready)) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    end_q  <= end_next;
    res_q  <= res_next;
    addr_q <= addr_next;
    if (in_valid && in_ready) begin
      cmd_q   <= command;
      start_q <= start_addr;
      len_q   <= region_len;
      nst_q   <= new_state;
    end
    if (state == S_PREP) begin
      lastf_q <= last_byte[SW-1:PAGE_SHIFT];
      first_q <= start_q[AddrInWidth-1:PAGE_SHIFT];
      cnt_q   <= cnt_bytes[SW-1:PAGE_SHIFT];
    end
    if (state == S_DONE && (!out_valid || out_ready)) begin
      status     <= res_q;
      frame_addr <= addr_q;
    end
  end

  a_no_write_when_idle: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE || state == S_DONE) |-> !mem_we)
    else $error("Frame memory written outside of a request.");

  a_write_in_region: assert property (@(posedge clk) disable iff (rst)
    (state == S_WRITE || state == S_CHK_RD) |-> (idx < end_q))
    else $error("Frame index left the marked region.");

  a_result_from_done: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> ($past(state) == S_DONE))
    else $error("Result presented without a finished request.");

  a_alloc_hit_ends: assert property (@(posedge clk) disable iff (rst)
    (state == S_AL_CMP && rdata == FS_KPOOL) |-> (mem_we ##1 state == S_DONE))
    else $error("Allocated frame not claimed.");

endmodule
